>>> sv/assert_macros.svh
// assertion macros for the rtl file that carries checks, the core top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define SQS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// next-cycle implication, disabled while reset is held
`define SQS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

>>> sv/sqs_pkg.sv
// package for the square root simplify core: widths, prime tables, microcode
// no dependencies
package sqs_pkg;

    localparam int VALUE_WIDTH       = 32;
    localparam int SMALL_PRIME_COUNT = 10;
    localparam int REM_W             = 31;
    localparam int ROOT_W            = 16;
    localparam int RAD_W             = 31;
    localparam int FACT_W            = 5;
    localparam int TAB_DEPTH         = 10;
    localparam int TAB_W             = 4;
    localparam int IDX_W             = $clog2(SMALL_PRIME_COUNT + 1);

    localparam logic [FACT_W-1:0] PRIME_TWO = 5'd2;

    // multiplicative inverse of an odd constant modulo 2^31, newton iteration
    function automatic logic [REM_W-1:0] inv_mod(input logic [31:0] p);
        logic [31:0] x;
        x = p;
        for (int i = 0; i < 5; i++) begin
            x = x * (32'd2 - p * x);
        end
        return x[REM_W-1:0];
    endfunction

    localparam logic [FACT_W-1:0] PRIME_TAB [TAB_DEPTH] = '{
        5'd2, 5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd17, 5'd19, 5'd23, 5'd29
    };

    // entry for two is unused: two is handled by a shift
    localparam logic [REM_W-1:0] INV_TAB [TAB_DEPTH] = '{
        31'd0,
        inv_mod(32'd3),  inv_mod(32'd5),  inv_mod(32'd7),  inv_mod(32'd11),
        inv_mod(32'd13), inv_mod(32'd17), inv_mod(32'd19), inv_mod(32'd23),
        inv_mod(32'd29)
    };

    // largest quotient of a 31-bit value; a product above it means no exact division
    localparam logic [REM_W-1:0] LIM_TAB [TAB_DEPTH] = '{
        31'd0,
        31'(32'h7FFF_FFFF / 3),  31'(32'h7FFF_FFFF / 5),  31'(32'h7FFF_FFFF / 7),
        31'(32'h7FFF_FFFF / 11), 31'(32'h7FFF_FFFF / 13), 31'(32'h7FFF_FFFF / 17),
        31'(32'h7FFF_FFFF / 19), 31'(32'h7FFF_FFFF / 23), 31'(32'h7FFF_FFFF / 29)
    };

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_TWO,
        OP_MUL,
        OP_TST,
        OP_FOLD,
        OP_LMUL
    } t_op;

    typedef enum logic [1:0] {
        BR_JUMP,
        BR_COND,
        BR_DISPATCH
    } t_br;

    typedef enum logic [1:0] {
        C_NONE,
        C_IN_XFER,
        C_OUT_XFER,
        C_REM_GT1
    } t_cond;

    typedef logic [2:0] t_step;

    localparam t_step ST_LOAD = 3'd0;
    localparam t_step ST_CHK  = 3'd1;
    localparam t_step ST_TWO  = 3'd2;
    localparam t_step ST_MUL  = 3'd3;
    localparam t_step ST_TST  = 3'd4;
    localparam t_step ST_FOLD = 3'd5;
    localparam t_step ST_LMUL = 3'd6;
    localparam t_step ST_DONE = 3'd7;

    typedef struct packed {
        logic  in_ready;
        logic  out_valid;
        t_op   op;
        t_br   br;
        t_cond cond;
        t_step target;
        t_step alt;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic in_xfer;
    } t_dp_ctrl;

    typedef struct packed {
        logic rem_gt1;
        logic exhausted;
        logic is_two;
    } t_dp_status;

    function automatic t_uword mk_uword(input logic rdy, input logic vld, input t_op op,
                                        input t_br br, input t_cond cond,
                                        input t_step target, input t_step alt);
        t_uword w;
        w.in_ready  = rdy;
        w.out_valid = vld;
        w.op        = op;
        w.br        = br;
        w.cond      = cond;
        w.target    = target;
        w.alt       = alt;
        return w;
    endfunction

    // microprogram
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        case (s)
            ST_LOAD: w = mk_uword(1'b1, 1'b0, OP_LOAD, BR_COND, C_IN_XFER, ST_CHK, ST_LOAD);
            ST_CHK:  w = mk_uword(1'b0, 1'b0, OP_NONE, BR_DISPATCH, C_NONE, ST_CHK, ST_CHK);
            ST_TWO:  w = mk_uword(1'b0, 1'b0, OP_TWO, BR_JUMP, C_NONE, ST_CHK, ST_CHK);
            ST_MUL:  w = mk_uword(1'b0, 1'b0, OP_MUL, BR_JUMP, C_NONE, ST_TST, ST_TST);
            ST_TST:  w = mk_uword(1'b0, 1'b0, OP_TST, BR_JUMP, C_NONE, ST_CHK, ST_CHK);
            ST_FOLD: w = mk_uword(1'b0, 1'b0, OP_FOLD, BR_COND, C_REM_GT1, ST_LMUL, ST_DONE);
            ST_LMUL: w = mk_uword(1'b0, 1'b0, OP_LMUL, BR_JUMP, C_NONE, ST_DONE, ST_DONE);
            ST_DONE: w = mk_uword(1'b0, 1'b1, OP_NONE, BR_COND, C_OUT_XFER, ST_LOAD, ST_DONE);
            default: w = mk_uword(1'b0, 1'b0, OP_NONE, BR_JUMP, C_NONE, ST_LOAD, ST_LOAD);
        endcase
        return w;
    endfunction

endpackage

>>> sv/sqs_in_if.sv
// input channel of the square root simplify core: valid, ready, value
// depends on sqs_pkg
interface sqs_in_if import sqs_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

>>> sv/sqs_out_if.sv
// result channel of the square root simplify core: valid, ready, root and radical
// depends on sqs_pkg
interface sqs_out_if import sqs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ROOT_W-1:0] root_part;
    logic [RAD_W-1:0]  radical_part;

    modport source (output valid, output root_part, output radical_part, input ready);
    modport sink   (input valid, input root_part, input radical_part, output ready);
endinterface

>>> sv/sqs_datapath.sv
// datapath of the square root simplify core: remainder, prime index, accumulators
// depends on sqs_pkg; driven by the microcode sequencer in the top level
module sqs_datapath import sqs_pkg::*; (
    input  logic                          i_clk,
    input  t_dp_ctrl                      i_ctrl,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output t_dp_status                    o_status,
    output logic [ROOT_W-1:0]             o_root,
    output logic [RAD_W-1:0]              o_radical
);

    logic [REM_W-1:0]  r_rem,     n_rem;
    logic [IDX_W-1:0]  r_idx,     n_idx;
    logic [FACT_W-1:0] r_pending, n_pending;
    logic [ROOT_W-1:0] r_root,    n_root;
    logic [RAD_W-1:0]  r_rad,     n_rad;
    logic [REM_W-1:0]  r_prod,    n_prod;

    logic [TAB_W-1:0]  w_tab;
    logic [FACT_W-1:0] w_prime;
    logic [REM_W-1:0]  w_inv;
    logic [REM_W-1:0]  w_lim;
    logic [REM_W-1:0]  w_mul_a;
    logic [REM_W-1:0]  w_mul_b;
    logic [REM_W-1:0]  w_mul;
    logic [RAD_W-1:0]  w_rad_pend;
    logic              w_neg;
    logic [VALUE_WIDTH-2:0] w_low;
    logic              w_trivial;
    logic              w_take;
    logic [FACT_W-1:0] w_f;

    assign w_tab   = TAB_W'(r_idx);
    assign w_prime = PRIME_TAB[w_tab];
    assign w_inv   = INV_TAB[w_tab];
    assign w_lim   = LIM_TAB[w_tab];

    // one shared multiplier: exact division step or leftover fold
    assign w_mul_a = (i_ctrl.op == OP_LMUL) ? r_rad : r_rem;
    assign w_mul_b = (i_ctrl.op == OP_LMUL) ? r_rem : w_inv;
    assign w_mul   = REM_W'(w_mul_a * w_mul_b);

    assign w_rad_pend = RAD_W'(r_rad * r_pending);

    assign w_neg     = i_value[VALUE_WIDTH-1];
    assign w_low     = i_value[VALUE_WIDTH-2:0];
    assign w_trivial = w_neg || (w_low <= (VALUE_WIDTH-1)'(1));

    always_comb begin
        n_rem     = r_rem;
        n_idx     = r_idx;
        n_pending = r_pending;
        n_root    = r_root;
        n_rad     = r_rad;
        n_prod    = r_prod;
        w_take    = 1'b0;
        w_f       = w_prime;
        case (i_ctrl.op)
            OP_LOAD: begin
                if (i_ctrl.in_xfer) begin
                    n_rem     = w_trivial ? '0 : REM_W'(w_low);
                    n_idx     = '0;
                    n_pending = '0;
                    n_root    = ROOT_W'(1);
                    n_rad     = RAD_W'(1);
                end
            end
            OP_TWO: begin
                if (!r_rem[0]) begin
                    n_rem  = r_rem >> 1;
                    w_take = 1'b1;
                    w_f    = PRIME_TWO;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            OP_MUL: begin
                n_prod = w_mul;
            end
            OP_TST: begin
                if (r_prod <= w_lim) begin
                    n_rem  = r_prod;
                    w_take = 1'b1;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            OP_FOLD: begin
                if (r_pending != '0) begin
                    n_rad = w_rad_pend;
                end
                n_pending = '0;
            end
            OP_LMUL: begin
                n_rad = w_mul;
            end
            default: begin
            end
        endcase
        // pair a new factor with the pending one or push the pending one under the root
        if (w_take) begin
            if (r_pending == w_f) begin
                n_root    = ROOT_W'(r_root * w_f);
                n_pending = '0;
            end else begin
                if (r_pending != '0) begin
                    n_rad = w_rad_pend;
                end
                n_pending = w_f;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_idx     <= n_idx;
        r_pending <= n_pending;
        r_root    <= n_root;
        r_rad     <= n_rad;
        r_prod    <= n_prod;
    end

    assign o_status.rem_gt1   = (r_rem > REM_W'(1));
    assign o_status.exhausted = (r_idx == IDX_W'(SMALL_PRIME_COUNT));
    assign o_status.is_two    = (w_prime == PRIME_TWO);
    assign o_root             = r_root;
    assign o_radical          = r_rad;

endmodule

>>> sv/square_root_simplify_core.sv
// square root simplify core: one value in, root and radical out, one item at a time
// steps: load takes the input, check dispatches; each factor of two, and the move past
// two when an odd part above one remains, runs the two step, each odd prime tried runs
// multiply then test; then fold, plus leftover multiply when a leftover above one remains
// next input is taken the cycle after the result transfer
// reset: synchronous active low, returns the step counter to the load step
`include "assert_macros.svh"

module square_root_simplify_core import sqs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sqs_in_if.sink      i_in,
    sqs_out_if.source   o_out
);

    t_step      r_step, n_step;
    t_uword     w_uw;
    t_dp_ctrl   w_ctrl;
    t_dp_status w_status;
    logic       w_in_xfer;
    logic       w_out_xfer;
    logic       w_cond;

    assign w_uw       = ucode(r_step);
    assign w_in_xfer  = i_in.valid && w_uw.in_ready;
    assign w_out_xfer = w_uw.out_valid && o_out.ready;

    always_comb begin
        case (w_uw.cond)
            C_IN_XFER:  w_cond = w_in_xfer;
            C_OUT_XFER: w_cond = w_out_xfer;
            C_REM_GT1:  w_cond = w_status.rem_gt1;
            default:    w_cond = 1'b0;
        endcase
    end

    always_comb begin
        case (w_uw.br)
            BR_JUMP: n_step = w_uw.target;
            BR_COND: n_step = w_cond ? w_uw.target : w_uw.alt;
            BR_DISPATCH: begin
                if (!w_status.rem_gt1 || w_status.exhausted) begin
                    n_step = ST_FOLD;
                end else if (w_status.is_two) begin
                    n_step = ST_TWO;
                end else begin
                    n_step = ST_MUL;
                end
            end
            default: n_step = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_LOAD;
        end else begin
            r_step <= n_step;
        end
    end

    assign w_ctrl.op      = w_uw.op;
    assign w_ctrl.in_xfer = w_in_xfer;

    sqs_datapath u_datapath (
        .i_clk     (i_clk),
        .i_ctrl    (w_ctrl),
        .i_value   (i_in.value),
        .o_status  (w_status),
        .o_root    (o_out.root_part),
        .o_radical (o_out.radical_part)
    );

    assign i_in.ready  = w_uw.in_ready;
    assign o_out.valid = w_uw.out_valid;

    `SQS_ASSERT_IMPLY(a_one_item, i_clk, i_rst_n, o_out.valid, !i_in.ready)
    `SQS_ASSERT_NEXT(a_load_to_chk, i_clk, i_rst_n, i_in.valid && i_in.ready, r_step == ST_CHK)
    `SQS_ASSERT_NEXT(a_out_to_load, i_clk, i_rst_n, o_out.valid && o_out.ready, r_step == ST_LOAD)
    `SQS_ASSERT_IMPLY(a_nonzero, i_clk, i_rst_n, o_out.valid, (|o_out.root_part) && (|o_out.radical_part))

endmodule
